[rtl/rwps_pkg.sv]
// ----------------------------------------------------------------------------
// rwps_pkg
// Shared types and constants of the raycast wall pixel shader: register
// indexes, region codes, texture ids, pipeline stage map and the word that
// travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rwps_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PLAYER_X   = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y   = 3'd1;
  localparam logic [2:0] REG_VIEW_ANGLE = 3'd2;
  localparam logic [2:0] REG_SCREEN_H   = 3'd3;
  localparam logic [2:0] REG_PROJ_DIST  = 3'd4;
  localparam logic [2:0] REG_CEIL_COLOR = 3'd5;
  localparam logic [2:0] REG_FLOOR_COLOR = 3'd6;

  localparam logic [11:0] SCREEN_H_RESET  = 12'd600;
  localparam logic [23:0] PROJ_DIST_RESET = 24'd221703;

  // region codes
  localparam logic [1:0] REGION_CEILING = 2'd0;
  localparam logic [1:0] REGION_WALL    = 2'd1;
  localparam logic [1:0] REGION_FLOOR   = 2'd2;

  // texture ids
  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_WEST  = 2'd2;
  localparam logic [1:0] TEX_EAST  = 2'd3;

  // tile and texture geometry (both 64)
  localparam int TILE_BITS = 6;
  localparam int TEX_BITS  = 6;
  localparam int TEX_AREA  = 1 << (2 * TEX_BITS);
  localparam int TEX_WORDS = 4 * TEX_AREA;
  localparam int ADDR_W    = 2 + 2 * TEX_BITS;

  // cosine series: x scale (Q30 radians per angle step) and divisors
  localparam logic [30:0] COS_XSCALE = 31'd102944;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam int COS_TERMS = 5;
  localparam logic [31:0] COS_DIV [COS_TERMS] = '{32'd90, 32'd56, 32'd30, 32'd12, 32'd2};
  localparam logic [31:0] COS_RECIP [COS_TERMS] = '{
    32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
    32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};

  // stage map
  localparam int SQ_STEPS     = 25;
  localparam int DIV_STEPS    = 24;
  localparam int ST_SQ_FIRST  = 3;
  localparam int ST_COS_FIRST = 3;
  localparam int ST_COS_FIN   = ST_COS_FIRST + 3 * COS_TERMS;
  localparam int ST_DIST      = ST_SQ_FIRST + SQ_STEPS;
  localparam int ST_OVF       = ST_DIST + 1;
  localparam int ST_DIV_FIRST = ST_OVF + 1;
  localparam int ST_STRIP     = ST_DIV_FIRST + DIV_STEPS;
  localparam int ST_EDGES     = ST_STRIP + 1;
  localparam int ST_REGION    = ST_EDGES + 1;
  localparam int ST_TY_FIRST  = ST_REGION + 1;
  localparam int ST_TADDR     = ST_TY_FIRST + TEX_BITS;
  localparam int ST_OUT       = ST_TADDR + 1;
  localparam int NSTAGE       = ST_OUT + 1;

  typedef struct packed {
    logic [23:0] player_x;
    logic [23:0] player_y;
    logic [15:0] view_angle;
    logic [11:0] screen_h;
    logic [23:0] proj_dist;
    logic [23:0] ceil_color;
    logic [23:0] floor_color;
  } cfg_t;

  typedef struct packed {
    logic                render;
    logic                emit;
    logic [11:0]         column;
    logic [10:0]         row;
    logic [1:0]          tid;
    logic [TEX_BITS-1:0] ox;
    logic [23:0]         wcolor;
    logic [ADDR_W-1:0]   waddr;
    logic [23:0]         dx;
    logic [23:0]         dy;
    logic [47:0]         sqx;
    logic [47:0]         sqy;
    logic [49:0]         sv;
    logic [49:0]         sr;
    logic                czero;
    logic [13:0]         u;
    logic [30:0]         x;
    logic [31:0]         x2;
    logic [30:0]         t;
    logic [61:0]         prod;
    logic [31:0]         q;
    logic [31:0]         est;
    logic [15:0]         cosv;
    logic [24:0]         d;
    logic                ovf;
    logic [37:0]         rem;
    logic [23:0]         quo;
    logic [23:0]         strip;
    logic signed [24:0]  topq;
    logic [24:0]         botq;
    logic signed [25:0]  dq;
    logic [1:0]          region;
    logic                big;
    logic [24:0]         orem;
    logic [TEX_BITS-1:0] oy;
  } item_t;

endpackage

`default_nettype wire

[rtl/raycast_wall_pixel_shader.sv]
// ----------------------------------------------------------------------------
// raycast_wall_pixel_shader
// Colors one pixel of a raycast wall column: distance, fisheye correction,
// strip height, region and texel lookup, fully pipelined.
// ----------------------------------------------------------------------------
// One word enters per clock while the output word is not held, through a
// 65-stage pipeline (25 square-root steps, a five-term cosine series, 24
// strip-height divide steps, 6 texel-row divide steps). Texel writes travel
// the same pipeline and land in the 16384 x 24 texture memory at the stage
// that also reads it, so writes and reads keep word order. When the output
// word is held, the whole pipeline holds.
`default_nettype none

module raycast_wall_pixel_shader (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [1:0]  texture_id,
  input  wire logic [11:0] texel_index,
  input  wire logic [23:0] texel_color,
  input  wire logic [11:0] column,
  input  wire logic [10:0] row,
  input  wire logic [23:0] hit_x,
  input  wire logic [23:0] hit_y,
  input  wire logic        hit_vertical,
  input  wire logic        facing_up,
  input  wire logic        facing_right,
  input  wire logic [15:0] ray_angle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      pixel_column,
  output logic [10:0]      pixel_row,
  output logic [23:0]      pixel_color,
  output logic [1:0]       region
);

  rwps_pkg::cfg_t  cfg;
  rwps_pkg::item_t entry;
  rwps_pkg::item_t pipe [rwps_pkg::NSTAGE];
  logic [rwps_pkg::NSTAGE-1:0] pv;
  logic [23:0] tex_mem [rwps_pkg::TEX_WORDS];
  logic [23:0] rdata;
  logic        adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.player_x    <= '0;
      cfg.player_y    <= '0;
      cfg.view_angle  <= '0;
      cfg.screen_h    <= rwps_pkg::SCREEN_H_RESET;
      cfg.proj_dist   <= rwps_pkg::PROJ_DIST_RESET;
      cfg.ceil_color  <= '0;
      cfg.floor_color <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwps_pkg::REG_PLAYER_X:    cfg.player_x    <= cfg_data;
        rwps_pkg::REG_PLAYER_Y:    cfg.player_y    <= cfg_data;
        rwps_pkg::REG_VIEW_ANGLE:  cfg.view_angle  <= cfg_data[15:0];
        rwps_pkg::REG_SCREEN_H:    cfg.screen_h    <= cfg_data[11:0];
        rwps_pkg::REG_PROJ_DIST:   cfg.proj_dist   <= cfg_data;
        rwps_pkg::REG_CEIL_COLOR:  cfg.ceil_color  <= cfg_data;
        rwps_pkg::REG_FLOOR_COLOR: cfg.floor_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid = pv[rwps_pkg::ST_OUT] & pipe[rwps_pkg::ST_OUT].render
                     & pipe[rwps_pkg::ST_OUT].emit;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  // stage 0: differences, angle fold, texture side
  always_comb begin
    logic [15:0] a;
    logic [16:0] uf;
    logic [23:0] hit;
    entry        = '0;
    entry.render = action;
    entry.column = column;
    entry.row    = row;
    entry.dx     = (hit_x >= cfg.player_x) ? hit_x - cfg.player_x : cfg.player_x - hit_x;
    entry.dy     = (hit_y >= cfg.player_y) ? hit_y - cfg.player_y : cfg.player_y - hit_y;
    a            = ray_angle - cfg.view_angle;
    uf           = a[15] ? 17'h10000 - {1'b0, a} : {1'b0, a};
    entry.czero  = (uf >= 17'd16384);
    entry.u      = uf[13:0];
    hit          = hit_vertical ? hit_y : hit_x;
    // tile and texture have the same size, so the column scale is one
    entry.ox     = hit[8 +: rwps_pkg::TILE_BITS];
    entry.wcolor = texel_color;
    entry.waddr  = {texture_id, texel_index};
    if (action) begin
      entry.emit = ({1'b0, row} < cfg.screen_h);
      if (hit_vertical) entry.tid = facing_right ? rwps_pkg::TEX_EAST : rwps_pkg::TEX_WEST;
      else entry.tid = facing_up ? rwps_pkg::TEX_NORTH : rwps_pkg::TEX_SOUTH;
    end else begin
      entry.emit = ({1'b0, texel_index} < 13'(rwps_pkg::TEX_AREA));
      entry.tid  = texture_id;
    end
  end

  function automatic rwps_pkg::item_t step(input int s, input rwps_pkg::item_t i,
                                           input rwps_pkg::cfg_t c);
    rwps_pkg::item_t o;
    logic [49:0] bq;
    logic [49:0] sum;
    logic [63:0] prod;
    logic [31:0] corr;
    logic [32:0] pq;
    logic [16:0] cv;
    logic [37:0] num;
    logic [48:0] dsh;
    logic [18:0] half256;
    logic [22:0] s2;
    logic [16:0] top;
    logic [16:0] bot;
    logic [24:0] rem2;
    logic [rwps_pkg::TEX_BITS-1:0] oyf;
    int j;
    o       = i;
    half256 = {c.screen_h[11:1], 8'd0};
    s2      = i.strip[23:1];
    num     = 38'(c.proj_dist) << (rwps_pkg::TILE_BITS + 8);  // TILE_SIZE * 256
    if (s == 1) begin
      o.sqx = {24'd0, i.dx} * {24'd0, i.dx};
      o.sqy = {24'd0, i.dy} * {24'd0, i.dy};
      o.x   = 31'(i.u) * rwps_pkg::COS_XSCALE;
    end
    if (s == 2) begin
      o.sv  = 50'(i.sqx) + 50'(i.sqy);
      o.sr  = '0;
      prod  = 64'(i.x) * 64'(i.x);
      o.x2  = prod[61:30];
      o.t   = rwps_pkg::Q30_ONE;
    end
    if (s >= rwps_pkg::ST_SQ_FIRST && s < rwps_pkg::ST_SQ_FIRST + rwps_pkg::SQ_STEPS) begin
      j   = s - rwps_pkg::ST_SQ_FIRST;
      bq  = 50'd1 << (48 - 2 * j);
      sum = i.sr + bq;
      if (i.sv >= sum) begin
        o.sv = i.sv - sum;
        o.sr = (i.sr >> 1) + bq;
      end else begin
        o.sr = i.sr >> 1;
      end
    end
    for (int n = 0; n < rwps_pkg::COS_TERMS; n++) begin
      if (s == rwps_pkg::ST_COS_FIRST + 3 * n) begin
        prod   = 64'(i.x2) * 64'(i.t);
        o.prod = prod[61:0];
      end
      if (s == rwps_pkg::ST_COS_FIRST + 3 * n + 1) begin
        o.q   = i.prod[61:30];
        prod  = 64'(i.prod[61:30]) * 64'(rwps_pkg::COS_RECIP[n]);
        o.est = prod[63:32];
      end
      if (s == rwps_pkg::ST_COS_FIRST + 3 * n + 2) begin
        corr = i.q - i.est * rwps_pkg::COS_DIV[n];
        pq   = (corr >= rwps_pkg::COS_DIV[n]) ? 33'(i.est) + 33'd1 : 33'(i.est);
        o.t  = (pq >= 33'(rwps_pkg::Q30_ONE)) ? '0 : 31'(33'(rwps_pkg::Q30_ONE) - pq);
      end
    end
    if (s == rwps_pkg::ST_COS_FIN) begin
      cv     = 17'(({1'b0, i.t} + 32'h4000) >> 15);
      if (cv > 17'd32768) cv = 17'd32768;
      o.cosv = i.czero ? '0 : cv[15:0];
    end
    if (s == rwps_pkg::ST_DIST) begin
      prod = 64'(i.sr[24:0]) * 64'(i.cosv);
      o.d  = prod[39:15];
    end
    if (s == rwps_pkg::ST_OVF) begin
      dsh   = {i.d, 24'd0};
      o.ovf = (i.d == '0) || (49'(num) >= dsh);
      o.rem = num;
      o.quo = '0;
    end
    if (s >= rwps_pkg::ST_DIV_FIRST && s < rwps_pkg::ST_DIV_FIRST + rwps_pkg::DIV_STEPS) begin
      j   = 23 - (s - rwps_pkg::ST_DIV_FIRST);
      dsh = 49'(i.d) << j;
      if (49'(i.rem) >= dsh) begin
        o.rem    = 38'(49'(i.rem) - dsh);
        o.quo[j] = 1'b1;
      end
    end
    if (s == rwps_pkg::ST_STRIP) o.strip = i.ovf ? 24'hFF_FFFF : i.quo;
    if (s == rwps_pkg::ST_EDGES) begin
      o.topq = $signed({6'd0, half256}) - $signed({2'd0, s2});
      o.botq = 25'(half256) + 25'(s2);
      o.dq   = $signed({7'd0, i.row, 8'd0}) + $signed({3'd0, s2})
               - $signed({7'd0, half256});
    end
    if (s == rwps_pkg::ST_REGION) begin
      top  = (i.topq <= 0) ? '0 : 17'(i.topq[24:8]);
      bot  = i.botq[24:8];
      if (bot > 17'(c.screen_h)) bot = 17'(c.screen_h);
      if (17'(i.row) < top) begin
        o.region = rwps_pkg::REGION_CEILING;
        o.wcolor = c.ceil_color;
      end else if (17'(i.row) < bot) begin
        o.region = rwps_pkg::REGION_WALL;
      end else begin
        o.region = rwps_pkg::REGION_FLOOR;
        o.wcolor = c.floor_color;
      end
      o.orem = (i.dq < 0) ? '0 : 25'(i.dq);
      o.big  = (o.orem >= 25'(i.strip));
      o.oy   = '0;
    end
    if (s >= rwps_pkg::ST_TY_FIRST && s < rwps_pkg::ST_TADDR) begin
      j    = rwps_pkg::TEX_BITS - 1 - (s - rwps_pkg::ST_TY_FIRST);
      rem2 = {i.orem[23:0], 1'b0};
      if (rem2 >= 25'(i.strip)) begin
        o.orem  = rem2 - 25'(i.strip);
        o.oy[j] = 1'b1;
      end else begin
        o.orem = rem2;
      end
    end
    if (s == rwps_pkg::ST_TADDR && i.render) begin
      oyf     = (i.strip == '0) ? '0 : (i.big ? '1 : i.oy);
      o.waddr = {i.tid, oyf, i.ox};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) pv <= '0;
    else if (adv) pv <= {pv[rwps_pkg::NSTAGE-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= entry;
      for (int s = 1; s < rwps_pkg::NSTAGE; s++) pipe[s] <= step(s, pipe[s-1], cfg);
    end
  end

  // texture memory: read and written at the address stage while the pipeline advances
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= tex_mem[pipe[rwps_pkg::ST_TADDR].waddr];
      if (pv[rwps_pkg::ST_TADDR] && !pipe[rwps_pkg::ST_TADDR].render
          && pipe[rwps_pkg::ST_TADDR].emit)
        tex_mem[pipe[rwps_pkg::ST_TADDR].waddr] <= pipe[rwps_pkg::ST_TADDR].wcolor;
    end
  end

  assign pixel_column = pipe[rwps_pkg::ST_OUT].column;
  assign pixel_row    = pipe[rwps_pkg::ST_OUT].row;
  assign region       = pipe[rwps_pkg::ST_OUT].region;
  assign pixel_color  = (pipe[rwps_pkg::ST_OUT].region == rwps_pkg::REGION_WALL) ?
                        rdata : pipe[rwps_pkg::ST_OUT].wcolor;

  a_wall_has_strip: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == rwps_pkg::REGION_WALL |-> pipe[rwps_pkg::ST_OUT].strip != '0)
    else $error("wall pixel with zero strip height");

  a_row_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, pixel_row} < cfg.screen_h)
    else $error("pixel row beyond screen height");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(pv))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> pv[0])
    else $error("accepted word missing from first stage");

endmodule

`default_nettype wire
